### rtl/otpa_pkg.sv
// otpa_pkg: shared codes, state encoding and result word for the or-tree page allocator
// depends on nothing; used by otpa_walker and or_tree_page_allocator
package otpa_pkg;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam int unsigned PAGE_W = 10;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_RANGE = 2'd2
  } otpa_status_e;

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_DOWN   = 5'b00100,
    ST_UP     = 5'b01000,
    ST_FINISH = 5'b10000
  } otpa_state_e;

  typedef struct packed {
    logic [PAGE_W-1:0] page;
    otpa_status_e      status;
  } otpa_result_t;

endpackage

### rtl/otpa_tree_mem.sv
// otpa_tree_mem: child-pair memory of the free tree, one entry per inner node
// entry n holds {bit of node 2n+1, bit of node 2n}; registered read, one write port
module otpa_tree_mem #(
  parameter int unsigned LEAF_COUNT = 1024
) (
  input  logic                          clk_i,
  input  logic                          rd_en_i,
  input  logic [$clog2(LEAF_COUNT)-1:0] rd_addr_i,
  output logic [1:0]                    rd_data_o,
  input  logic                          wr_en_i,
  input  logic [$clog2(LEAF_COUNT)-1:0] wr_addr_i,
  input  logic [1:0]                    wr_data_i
);

  logic [1:0] mem_q [LEAF_COUNT];
  logic [1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### rtl/otpa_walker.sv
// otpa_walker: sequencer that walks the tree down for allocate and up for every update
// depends on otpa_pkg; drives the ports of otpa_tree_mem
module otpa_walker #(
  parameter int unsigned LEAF_COUNT = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          kind_i,
  input  logic [otpa_pkg::PAGE_W-1:0]   page_number_i,
  output logic                          res_valid_o,
  input  logic                          res_take_i,
  output otpa_pkg::otpa_result_t        res_o,
  output logic                          rd_en_o,
  output logic [$clog2(LEAF_COUNT)-1:0] rd_addr_o,
  input  logic [1:0]                    rd_data_i,
  output logic                          wr_en_o,
  output logic [$clog2(LEAF_COUNT)-1:0] wr_addr_o,
  output logic [1:0]                    wr_data_o
);

  localparam int unsigned AW = $clog2(LEAF_COUNT);
  localparam int unsigned NW = AW + 1;

  otpa_pkg::otpa_state_e state_q, state_d;
  logic [AW-1:0]          cur_q, cur_d;
  logic                   sel_q, sel_d;
  logic                   val_q, val_d;
  logic [AW-1:0]          clr_q, clr_d;
  otpa_pkg::otpa_result_t res_q, res_d;

  logic [AW-1:0] page_aw;
  logic [NW-1:0] free_leaf;
  logic          page_bad;
  logic [NW-1:0] child;
  logic          leaf_hit;
  logic          mod_sel;
  logic          mod_val;
  logic [1:0]    new_pair;

  assign page_aw   = AW'(page_number_i);
  assign free_leaf = NW'(LEAF_COUNT) + NW'(page_aw);
  assign page_bad  = 32'(page_number_i) >= 32'(LEAF_COUNT);

  // prefer the left child when it has a free page
  assign child    = {cur_q, ~rd_data_i[0]};
  assign leaf_hit = child >= NW'(LEAF_COUNT);

  // on the way down the found leaf is cleared, on the way up the carried bit is stored
  assign mod_sel = (state_q == otpa_pkg::ST_DOWN) ? child[0] : sel_q;
  assign mod_val = (state_q == otpa_pkg::ST_DOWN) ? 1'b0 : val_q;

  always_comb begin
    new_pair          = rd_data_i;
    new_pair[mod_sel] = mod_val;
  end

  always_comb begin
    state_d   = state_q;
    cur_d     = cur_q;
    sel_d     = sel_q;
    val_d     = val_q;
    clr_d     = clr_q;
    res_d     = res_q;
    rd_en_o   = 1'b0;
    rd_addr_o = '0;
    wr_en_o   = 1'b0;
    wr_addr_o = '0;
    wr_data_o = '0;

    case (state_q)
      otpa_pkg::ST_CLEAR: begin
        wr_en_o   = 1'b1;
        wr_addr_o = clr_q;
        clr_d     = clr_q + AW'(1);
        if (clr_q == AW'(LEAF_COUNT - 1)) begin
          state_d = otpa_pkg::ST_IDLE;
        end
      end
      otpa_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          res_d.page   = '0;
          res_d.status = otpa_pkg::STAT_OK;
          if (kind_i == otpa_pkg::KIND_FREE) begin
            if (page_bad) begin
              res_d.status = otpa_pkg::STAT_RANGE;
              state_d      = otpa_pkg::ST_FINISH;
            end else begin
              cur_d     = free_leaf[NW-1:1];
              sel_d     = free_leaf[0];
              val_d     = 1'b1;
              rd_en_o   = 1'b1;
              rd_addr_o = free_leaf[NW-1:1];
              state_d   = otpa_pkg::ST_UP;
            end
          end else begin
            cur_d     = AW'(1);
            rd_en_o   = 1'b1;
            rd_addr_o = AW'(1);
            state_d   = otpa_pkg::ST_DOWN;
          end
        end
      end
      otpa_pkg::ST_DOWN, otpa_pkg::ST_UP: begin
        if ((state_q == otpa_pkg::ST_DOWN) && (rd_data_i == 2'b00)) begin
          res_d.status = otpa_pkg::STAT_EMPTY;
          state_d      = otpa_pkg::ST_FINISH;
        end else if ((state_q == otpa_pkg::ST_DOWN) && !leaf_hit) begin
          cur_d     = child[AW-1:0];
          rd_en_o   = 1'b1;
          rd_addr_o = child[AW-1:0];
        end else begin
          if (state_q == otpa_pkg::ST_DOWN) begin
            res_d.page = otpa_pkg::PAGE_W'(child - NW'(LEAF_COUNT));
          end
          wr_en_o   = 1'b1;
          wr_addr_o = cur_q;
          wr_data_o = new_pair;
          if (cur_q == AW'(1)) begin
            state_d = otpa_pkg::ST_FINISH;
          end else begin
            // carry the or of this pair into the parent's entry
            cur_d     = cur_q >> 1;
            sel_d     = cur_q[0];
            val_d     = |new_pair;
            rd_en_o   = 1'b1;
            rd_addr_o = cur_q >> 1;
            state_d   = otpa_pkg::ST_UP;
          end
        end
      end
      otpa_pkg::ST_FINISH: begin
        if (res_take_i) begin
          state_d = otpa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = otpa_pkg::ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= otpa_pkg::ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    sel_q <= sel_d;
    val_q <= val_d;
    res_q <= res_d;
  end

  assign in_stall_o  = (state_q != otpa_pkg::ST_IDLE);
  assign res_valid_o = (state_q == otpa_pkg::ST_FINISH);
  assign res_o       = res_q;

`ifndef NO_ASSERTIONS
  a_no_same_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_en_o && wr_en_o) |-> (rd_addr_o != wr_addr_o))
    else $error("read and write hit the same entry");

  a_walk_node_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == otpa_pkg::ST_DOWN) || (state_q == otpa_pkg::ST_UP)) |-> (cur_q != '0))
    else $error("walk reached the unused entry");

  a_fail_page_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (res_o.status != otpa_pkg::STAT_OK)) |-> (res_o.page == '0))
    else $error("failed word carries a page");

  a_empty_at_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == otpa_pkg::ST_DOWN) && (rd_data_i == 2'b00)) |-> (cur_q == AW'(1)))
    else $error("tree lost its or invariant below the root");
`endif

endmodule

### rtl/or_tree_page_allocator.sv
// timing: an allocate reads one memory entry per level on the way down from the root, then does one
// read-modify-write per level back up; a free does only the way up, an allocate on an empty pool
// stops at the root read and an out-of-range free goes straight to the result; one word in flight,
// the next accepted only once the walker has handed its result to the output register
// reset: the memory is cleared one entry a cycle with the input stalled,
// then no page is free; a result held in the stalled output register delays the next word
module or_tree_page_allocator #(
  parameter int unsigned LEAF_COUNT = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                kind_i,
  input  logic [otpa_pkg::PAGE_W-1:0]         page_number_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [otpa_pkg::PAGE_W-1:0]         granted_page_o,
  output logic [1:0]                          status_o
);

  localparam int unsigned AW = $clog2(LEAF_COUNT);

  logic                   res_valid;
  logic                   res_take;
  otpa_pkg::otpa_result_t res;
  logic                   rd_en;
  logic [AW-1:0]          rd_addr;
  logic [1:0]             rd_data;
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [1:0]             wr_data;

  logic                   out_valid_q;
  otpa_pkg::otpa_result_t out_q;

  otpa_walker #(
    .LEAF_COUNT(LEAF_COUNT)
  ) u_walker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_i),
    .page_number_i(page_number_i),
    .res_valid_o  (res_valid),
    .res_take_i   (res_take),
    .res_o        (res),
    .rd_en_o      (rd_en),
    .rd_addr_o    (rd_addr),
    .rd_data_i    (rd_data),
    .wr_en_o      (wr_en),
    .wr_addr_o    (wr_addr),
    .wr_data_o    (wr_data)
  );

  otpa_tree_mem #(
    .LEAF_COUNT(LEAF_COUNT)
  ) u_mem (
    .clk_i    (clk_i),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data)
  );

  // output word register frees the walker while the consumer stalls
  assign res_take = res_valid && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign granted_page_o = out_q.page;
  assign status_o       = out_q.status;

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps
// tb_top: self-checking bench for or_tree_page_allocator, directed words then random traffic
// depends on otpa_pkg and the allocator rtl; keeps its own copy of the free-page or-tree

module tb_top;

  localparam int unsigned LEAVES       = 1024;
  localparam int unsigned RANDOM_WORDS = 1030;
  localparam int unsigned LONG_HOLD    = 300;

  // shadow of the allocator tree plus the grants still owed by the block
  class page_pool_model;
    bit                          free_bit[2*LEAVES];
    otpa_pkg::otpa_result_t      expected_grants[$];
    logic [otpa_pkg::PAGE_W-1:0] last_grant = '0;
    int unsigned                 free_pages = 0;
    int unsigned                 errors     = 0;

    function void rebuild_path(int unsigned leaf);
      int unsigned n;
      n = leaf / 2;
      while (n >= 1) begin
        free_bit[n] = free_bit[2*n] | free_bit[2*n+1];
        n = n / 2;
      end
    endfunction

    function void take_request(logic kind, logic [otpa_pkg::PAGE_W-1:0] page);
      otpa_pkg::otpa_result_t res;
      int unsigned            node;
      res.page   = '0;
      res.status = otpa_pkg::STAT_OK;
      if (kind == otpa_pkg::KIND_FREE) begin
        if (page >= LEAVES) begin
          res.status = otpa_pkg::STAT_RANGE;
        end else begin
          node = LEAVES + page;
          if (!free_bit[node]) free_pages++;
          free_bit[node] = 1'b1;
          rebuild_path(node);
        end
      end else begin
        // walk down, left child first
        node = 1;
        while (node < LEAVES && res.status == otpa_pkg::STAT_OK) begin
          if (free_bit[2*node]) node = 2*node;
          else if (free_bit[2*node+1]) node = 2*node + 1;
          else res.status = otpa_pkg::STAT_EMPTY;
        end
        if (res.status == otpa_pkg::STAT_OK) begin
          free_bit[node] = 1'b0;
          rebuild_path(node);
          free_pages--;
          res.page   = otpa_pkg::PAGE_W'(node - LEAVES);
          last_grant = res.page;
        end
      end
      expected_grants.push_back(res);
    endfunction

    task report(string what);
      $display("%0t ns mismatch: %s", $time, what);
      errors++;
    endtask

    task check_grant(logic [otpa_pkg::PAGE_W-1:0] page, logic [1:0] status);
      otpa_pkg::otpa_result_t want;
      if (expected_grants.size() == 0) begin
        report($sformatf("unexpected word page %0d status %0d", page, status));
        return;
      end
      want = expected_grants.pop_front();
      if (page !== want.page)
        report($sformatf("granted_page %0d, expected %0d", page, want.page));
      if (status !== want.status)
        report($sformatf("status %0d, expected %0d", status, want.status));
    endtask
  endclass

  logic                        clk_i         = 1'b0;
  logic                        rst_ni        = 1'b0;
  logic                        in_valid      = 1'b0;
  logic                        in_stall;
  logic                        kind          = otpa_pkg::KIND_ALLOC;
  logic [otpa_pkg::PAGE_W-1:0] page_number   = '0;
  logic                        out_valid;
  logic                        out_stall     = 1'b0;
  logic [otpa_pkg::PAGE_W-1:0] granted_page;
  logic [1:0]                  status;

  int unsigned send_idle_pct = 27;
  int unsigned recv_idle_pct = 70;
  int unsigned hold_left     = 0;

  page_pool_model pool = new();

  or_tree_page_allocator #(
    .LEAF_COUNT(LEAVES)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .kind_i        (kind),
    .page_number_i (page_number),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .granted_page_o(granted_page),
    .status_o      (status)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // receiver: random stalls, or a long hold-off when one is requested
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) pool.check_grant(granted_page, status);
  end

  task automatic send_word(input logic k, input logic [otpa_pkg::PAGE_W-1:0] p);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid    <= 1'b1;
    kind        <= k;
    page_number <= p;
    do @(posedge clk_i); while (in_stall);
    pool.take_request(k, p);
  endtask

  task automatic request_page();
    send_word(otpa_pkg::KIND_ALLOC, otpa_pkg::PAGE_W'($urandom_range(LEAVES - 1)));
  endtask

  initial begin
    int unsigned                 burst_left;
    logic                        burst_kind;
    logic [otpa_pkg::PAGE_W-1:0] pick;
    int unsigned                 roll;

    burst_left = 0;
    burst_kind = otpa_pkg::KIND_ALLOC;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // empty pool right after reset, page field ignored
    send_word(otpa_pkg::KIND_ALLOC, '0);
    send_word(otpa_pkg::KIND_ALLOC, '1);
    // extremes of the page field, then a double free
    send_word(otpa_pkg::KIND_FREE, '0);
    send_word(otpa_pkg::KIND_FREE, '1);
    send_word(otpa_pkg::KIND_FREE, 10'd512);
    send_word(otpa_pkg::KIND_FREE, '0);
    request_page();
    request_page();
    request_page();
    request_page();
    // alternating bit patterns
    send_word(otpa_pkg::KIND_FREE, 10'h155);
    send_word(otpa_pkg::KIND_FREE, 10'h2aa);
    send_word(otpa_pkg::KIND_FREE, 10'd1);
    send_word(otpa_pkg::KIND_FREE, 10'h2aa);
    request_page();
    request_page();
    request_page();
    request_page();
    send_word(otpa_pkg::KIND_FREE, 10'd1022);
    send_word(otpa_pkg::KIND_FREE, 10'd1023);
    request_page();
    request_page();

    for (int unsigned i = 0; i < RANDOM_WORDS; i++) begin
      if (i == RANDOM_WORDS / 3) begin
        send_idle_pct = 70;
        recv_idle_pct = 27;
      end
      if (i == 2 * RANDOM_WORDS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left     = LONG_HOLD;
      end
      if (burst_left == 0) begin
        burst_left = $urandom_range(24, 1);
        roll       = $urandom_range(99);
        if (pool.free_pages < 16) begin
          burst_kind = (roll < 75) ? otpa_pkg::KIND_FREE : otpa_pkg::KIND_ALLOC;
        end else if (pool.free_pages > 600) begin
          burst_kind = (roll < 75) ? otpa_pkg::KIND_ALLOC : otpa_pkg::KIND_FREE;
        end else begin
          burst_kind = (roll < 50) ? otpa_pkg::KIND_FREE : otpa_pkg::KIND_ALLOC;
        end
      end
      burst_left--;
      roll = $urandom_range(99);
      if (roll < 50) pick = otpa_pkg::PAGE_W'($urandom_range(LEAVES - 1));
      else if (roll < 75) pick = otpa_pkg::PAGE_W'($urandom_range(63));
      else pick = pool.last_grant;
      send_word(burst_kind, pick);
    end
    @(negedge clk_i) in_valid <= 1'b0;

    while (pool.expected_grants.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (pool.errors == 0 && pool.expected_grants.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
